>>> rtl/crc16_frame_builder_core_assert.svh
// assertion macros for the frame builder rtl
`ifndef CRC16_FRAME_BUILDER_CORE_ASSERT_SVH
`define CRC16_FRAME_BUILDER_CORE_ASSERT_SVH

// same-cycle implication, checked while out of reset
`define CRCFB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("crcfb same-cycle check failed");

// next-cycle implication, checked while out of reset
`define CRCFB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("crcfb next-cycle check failed");

`endif

>>> rtl/crcfb_pkg.sv
// package: types, constants and crc step for the frame builder
package crcfb_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned CRC_W  = 16;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
	localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

	localparam logic [BYTE_W-1:0] START_MARKER_RST  = 8'hD0;
	localparam logic [BYTE_W-1:0] ENCODING_BYTE_RST = 8'h01;
	localparam logic [BYTE_W-1:0] ADDRESS_BYTE_RST  = 8'h0B;
	localparam logic [BYTE_W-1:0] END_MARKER_RST    = 8'hD1;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_START_MARKER  = 2'd0,
		CFG_ENCODING_BYTE = 2'd1,
		CFG_ADDRESS_BYTE  = 2'd2,
		CFG_END_MARKER    = 2'd3
	} cfg_idx_t;

	// register values handed to the emitter
	typedef struct packed {
		logic [BYTE_W-1:0] start_marker;
		logic [BYTE_W-1:0] encoding_byte;
		logic [BYTE_W-1:0] address_byte;
		logic [BYTE_W-1:0] end_marker;
	} cfg_t;

	// position within the bytes one word produces
	typedef enum logic [3:0] {
		SLOT_HDR_START = 4'd0,
		SLOT_HDR_CMD   = 4'd1,
		SLOT_HDR_ENC   = 4'd2,
		SLOT_HDR_ADDR  = 4'd3,
		SLOT_HDR_LEN   = 4'd4,
		SLOT_PAYLOAD   = 4'd5,
		SLOT_END       = 4'd6,
		SLOT_CRC_LO    = 4'd7,
		SLOT_CRC_HI    = 4'd8
	} slot_t;

	// one byte through the reflected crc-16
	function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc,
		input logic [BYTE_W-1:0] b);
		logic [CRC_W-1:0] c;
		c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
		for (int k = 0; k < BYTE_W; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

>>> rtl/crcfb_if.sv
// valid/ready channel interfaces for input and output words
interface crcfb_in_if
	import crcfb_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] command;
	logic [BYTE_W-1:0] length_field;
	logic [BYTE_W-1:0] payload_byte;
	logic              first;
	logic              last;

	modport source (output valid, command, length_field, payload_byte, first, last,
		input ready);
	modport sink (input valid, command, length_field, payload_byte, first, last,
		output ready);
endinterface

interface crcfb_out_if
	import crcfb_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic              run_last;
	logic              frame_last;

	modport source (output valid, out_byte, run_last, frame_last, input ready);
	modport sink (input valid, out_byte, run_last, frame_last, output ready);
endinterface

>>> rtl/crcfb_cfg_regs.sv
// configuration register file for the header and trailer bytes
module crcfb_cfg_regs
	import crcfb_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BYTE_W-1:0]    cfg_wdata,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	// register writes by index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_marker  <= START_MARKER_RST;
			cfg_q.encoding_byte <= ENCODING_BYTE_RST;
			cfg_q.address_byte  <= ADDRESS_BYTE_RST;
			cfg_q.end_marker    <= END_MARKER_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_START_MARKER:  cfg_q.start_marker  <= cfg_wdata;
				CFG_ENCODING_BYTE: cfg_q.encoding_byte <= cfg_wdata;
				CFG_ADDRESS_BYTE:  cfg_q.address_byte  <= cfg_wdata;
				CFG_END_MARKER:    cfg_q.end_marker    <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> rtl/crcfb_emitter.sv
// word register, byte sequencer, running crc and output register
`include "crc16_frame_builder_core_assert.svh"

module crcfb_emitter
	import crcfb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	crcfb_in_if.sink    in_ch,
	crcfb_out_if.source out_ch
);

	// input stage
	logic              v_s1;
	slot_t             slot_s1;
	logic [BYTE_W-1:0] command_s1;
	logic [BYTE_W-1:0] length_s1;
	logic [BYTE_W-1:0] payload_s1;
	logic              last_s1;

	// output register and crc
	logic              out_v_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              run_last_q;
	logic              frame_last_q;
	logic [CRC_W-1:0]  crc_q;

	logic              adv;
	logic              done;
	logic              accept;
	slot_t             slot_nxt;
	logic [BYTE_W-1:0] cur_byte;
	logic [CRC_W-1:0]  crc_base;
	logic [CRC_W-1:0]  crc_fed;

	// one byte leaves the stage whenever the output register is free
	assign adv    = v_s1 && (!out_v_q || out_ch.ready);
	assign done   = (slot_s1 == SLOT_CRC_HI) || ((slot_s1 == SLOT_PAYLOAD) && !last_s1);
	assign in_ch.ready = !v_s1 || (adv && done);
	assign accept = in_ch.valid && in_ch.ready;

	// next slot
	always_comb begin
		case (slot_s1)
			SLOT_HDR_START: slot_nxt = SLOT_HDR_CMD;
			SLOT_HDR_CMD:   slot_nxt = SLOT_HDR_ENC;
			SLOT_HDR_ENC:   slot_nxt = SLOT_HDR_ADDR;
			SLOT_HDR_ADDR:  slot_nxt = SLOT_HDR_LEN;
			SLOT_HDR_LEN:   slot_nxt = SLOT_PAYLOAD;
			SLOT_PAYLOAD:   slot_nxt = SLOT_END;
			SLOT_END:       slot_nxt = SLOT_CRC_LO;
			SLOT_CRC_LO:    slot_nxt = SLOT_CRC_HI;
			default:        slot_nxt = SLOT_PAYLOAD;
		endcase
	end

	// byte for the current slot
	always_comb begin
		case (slot_s1)
			SLOT_HDR_START: cur_byte = cfg.start_marker;
			SLOT_HDR_CMD:   cur_byte = command_s1;
			SLOT_HDR_ENC:   cur_byte = cfg.encoding_byte;
			SLOT_HDR_ADDR:  cur_byte = cfg.address_byte;
			SLOT_HDR_LEN:   cur_byte = length_s1;
			SLOT_PAYLOAD:   cur_byte = payload_s1;
			SLOT_END:       cur_byte = cfg.end_marker;
			SLOT_CRC_LO:    cur_byte = crc_q[BYTE_W-1:0];
			SLOT_CRC_HI:    cur_byte = crc_q[CRC_W-1:BYTE_W];
			default:        cur_byte = payload_s1;
		endcase
	end

	// crc restarts on the start marker
	assign crc_base = (slot_s1 == SLOT_HDR_START) ? CRC_INIT : crc_q;
	assign crc_fed  = crc_feed(crc_base, cur_byte);

	// stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			slot_s1 <= SLOT_PAYLOAD;
		end else if (accept) begin
			v_s1    <= 1'b1;
			slot_s1 <= in_ch.first ? SLOT_HDR_START : SLOT_PAYLOAD;
		end else if (adv && done) begin
			v_s1    <= 1'b0;
		end else if (adv) begin
			slot_s1 <= slot_nxt;
		end
	end

	// word fields
	always_ff @(posedge clk) begin
		if (accept) begin
			command_s1 <= in_ch.command;
			length_s1  <= in_ch.length_field;
			payload_s1 <= in_ch.payload_byte;
			last_s1    <= in_ch.last;
		end
	end

	// running crc
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_INIT;
		end else if (adv) begin
			case (slot_s1) inside
				SLOT_CRC_HI: crc_q <= CRC_INIT;
				SLOT_CRC_LO: crc_q <= crc_q;
				default:     crc_q <= crc_fed;
			endcase
		end
	end

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_v_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (adv) begin
			out_byte_q   <= cur_byte;
			run_last_q   <= done;
			frame_last_q <= (slot_s1 == SLOT_CRC_HI);
		end
	end

	assign out_ch.valid      = out_v_q;
	assign out_ch.out_byte   = out_byte_q;
	assign out_ch.run_last   = run_last_q;
	assign out_ch.frame_last = frame_last_q;

	// checks
	`CRCFB_ASSERT_NOW(a_frame_end_closes_word, clk, arst_n,
		out_v_q && frame_last_q, run_last_q)
	`CRCFB_ASSERT_NEXT(a_crc_restart_after_frame, clk, arst_n,
		adv && (slot_s1 == SLOT_CRC_HI), crc_q == CRC_INIT)
	`CRCFB_ASSERT_NOW(a_trailer_needs_last, clk, arst_n,
		v_s1 && (slot_s1 == SLOT_END || slot_s1 == SLOT_CRC_LO || slot_s1 == SLOT_CRC_HI),
		last_s1)

endmodule

>>> rtl/crc16_frame_builder_core.sv
// top level of the crc-16 frame builder
//
//  channel   dir  handshake        carries
//  in_ch     in   valid / ready    command, length_field, payload_byte, first, last
//  out_ch    out  valid / ready    out_byte, run_last, frame_last
//  cfg       in   cfg_we only      cfg_index, cfg_wdata
//
// one byte per cycle if unstalled; a word makes 1, 6 with first, 4 with last, 9 with both
// payload-only words enter each unstalled cycle; header and trailer bytes hold in_ch.ready low
// the output register lets the next word enter while a byte waits on out_ch
// reset (arst_n low) empties both stages and loads crc 0xFFFF and default markers
module crc16_frame_builder_core
	import crcfb_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	crcfb_in_if.sink             in_ch,
	crcfb_out_if.source          out_ch,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BYTE_W-1:0]    cfg_wdata
);

	cfg_t cfg;

	// configuration registers
	crcfb_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// byte sequencer and crc
	crcfb_emitter u_emit (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

endmodule
